// File: sv/tdss_pkg.sv
`default_nettype none
package tdss_pkg;

  localparam int unsigned SHIFT_BITS_DEF = 32;
  localparam int unsigned SEG_WIDTH      = 32;
  localparam int unsigned FIFO_DEPTH     = 2;

  localparam logic PULSE_CLOCK = 1'b0;
  localparam logic PULSE_LATCH = 1'b1;

  localparam logic ACT_NUMBER = 1'b0;
  localparam logic ACT_RAW    = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] number;
    logic [31:0] raw_word;
  } in_word_t;

  typedef struct packed {
    logic pulse_kind;
    logic data_bit;
    logic last_pulse;
  } out_word_t;

  typedef struct packed {
    logic                 valid;
    logic [SEG_WIDTH-1:0] word;
  } seg_xfer_t;

  function automatic logic [12:0] div10(input logic [15:0] n);
    logic [32:0] p;
    p = {17'b0, n} * 33'd52429;
    return p[31:19];
  endfunction

  function automatic logic [3:0] rem10(input logic [15:0] n, input logic [12:0] q);
    logic [15:0] q10;
    q10 = ({3'b0, q} << 3) + ({3'b0, q} << 1);
    return 4'(n - q10);
  endfunction

  function automatic logic [15:0] outer_seg(input logic [3:0] d);
    logic [15:0] s;
    unique case (d)
      4'd0:    s = 16'h7007;
      4'd1:    s = 16'h4001;
      4'd2:    s = 16'h300B;
      4'd3:    s = 16'h600B;
      4'd4:    s = 16'h400D;
      4'd5:    s = 16'h600E;
      4'd6:    s = 16'h700E;
      4'd7:    s = 16'h4003;
      4'd8:    s = 16'h700F;
      4'd9:    s = 16'h600F;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] middle_seg(input logic [3:0] d);
    logic [15:0] s;
    unique case (d)
      4'd0:    s = 16'h0770;
      4'd1:    s = 16'h0410;
      4'd2:    s = 16'h03B0;
      4'd3:    s = 16'h06B0;
      4'd4:    s = 16'h04D0;
      4'd5:    s = 16'h06E0;
      4'd6:    s = 16'h07E0;
      4'd7:    s = 16'h0430;
      4'd8:    s = 16'h07F0;
      4'd9:    s = 16'h06F0;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: sv/tdss_front.sv
`default_nettype none
module tdss_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire tdss_pkg::in_word_t in_word_i,
  output tdss_pkg::seg_xfer_t     wr_o,
  input  wire logic               wr_full_i
);
  import tdss_pkg::*;

  logic        v0_q, v1_q, v2_q;
  logic        act0_q, act1_q, act2_q;
  logic [15:0] num0_q;
  logic [31:0] raw0_q, raw1_q, raw2_q;
  logic [12:0] q1_q;
  logic [9:0]  q2_q;
  logic [3:0]  u1_q, u2_q, t2_q;

  logic        adv0, adv1, adv2, rdy0, rdy1, rdy2;
  logic [12:0] q1_d, q2_full, q3;
  logic [3:0]  u1_d, t2_d, hund;
  logic [31:0] num_word;

  assign adv2 = v2_q && !wr_full_i;
  assign rdy2 = !v2_q || adv2;
  assign adv1 = v1_q && rdy2;
  assign rdy1 = !v1_q || adv1;
  assign adv0 = v0_q && rdy1;
  assign rdy0 = !v0_q || adv0;
  assign full_o = !rdy0;

  // units digit
  assign q1_d = div10(num0_q);
  assign u1_d = rem10(num0_q, q1_d);

  // tens digit
  assign q2_full = div10({3'b0, q1_q});
  assign t2_d    = rem10({3'b0, q1_q}, q2_full);

  // hundreds digit
  assign q3   = div10({6'b0, q2_q});
  assign hund = rem10({6'b0, q2_q}, q3);

  assign num_word = {outer_seg(hund), 16'h0000}
                  | {16'h0000, middle_seg(t2_q) | outer_seg(u2_q)};

  always_comb begin
    wr_o.valid = adv2;
    wr_o.word  = (act2_q == ACT_RAW) ? raw2_q : num_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= push_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && rdy0) begin
      act0_q <= in_word_i.action;
      num0_q <= in_word_i.number;
      raw0_q <= in_word_i.raw_word;
    end
    if (adv0) begin
      act1_q <= act0_q;
      raw1_q <= raw0_q;
      q1_q   <= q1_d;
      u1_q   <= u1_d;
    end
    if (adv1) begin
      act2_q <= act1_q;
      raw2_q <= raw1_q;
      q2_q   <= q2_full[9:0];
      u2_q   <= u1_q;
      t2_q   <= t2_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/tdss_fifo.sv
`default_nettype none
module tdss_fifo #(
  parameter int unsigned DEPTH = tdss_pkg::FIFO_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tdss_pkg::seg_xfer_t wr_i,
  output logic                     full_o,
  output tdss_pkg::seg_xfer_t      rd_o,
  input  wire logic                pop_i
);
  import tdss_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [SEG_WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.word  = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && rd_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i.valid && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i.valid && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) mem_q[wr_ptr_q] <= wr_i.word;
  end

endmodule
`default_nettype wire

// File: sv/tdss_back.sv
`default_nettype none
module tdss_back #(
  parameter int unsigned SHIFT_BITS = tdss_pkg::SHIFT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tdss_pkg::seg_xfer_t rd_i,
  output logic                     pop_o,
  output logic                     empty_o,
  output tdss_pkg::out_word_t      out_word_o,
  input  wire logic                pop_i
);
  import tdss_pkg::*;

  localparam int unsigned CW = $clog2(SHIFT_BITS + 1);

  logic                 busy_q, busy_d;
  logic                 out_v_q, out_v_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [SEG_WIDTH-1:0] sh_q, sh_d;
  out_word_t            out_q, out_d;
  logic                 slot_free;

  assign slot_free  = !out_v_q || pop_i;
  assign empty_o    = !out_v_q;
  assign out_word_o = out_q;

  always_comb begin
    busy_d  = busy_q;
    out_v_d = out_v_q && !pop_i;
    cnt_d   = cnt_q;
    sh_d    = sh_q;
    out_d   = out_q;
    pop_o   = 1'b0;
    if (slot_free) begin
      if (busy_q) begin
        out_v_d = 1'b1;
        if (cnt_q == CW'(SHIFT_BITS)) begin
          out_d  = '{pulse_kind: PULSE_LATCH, data_bit: 1'b0, last_pulse: 1'b1};
          busy_d = 1'b0;
        end else begin
          out_d = '{pulse_kind: PULSE_CLOCK, data_bit: sh_q[0], last_pulse: 1'b0};
          sh_d  = sh_q >> 1;
          cnt_d = cnt_q + 1'b1;
        end
      end else if (rd_i.valid) begin
        // first bit goes out as the word is loaded
        pop_o   = 1'b1;
        out_v_d = 1'b1;
        busy_d  = 1'b1;
        out_d   = '{pulse_kind: PULSE_CLOCK, data_bit: rd_i.word[0], last_pulse: 1'b0};
        sh_d    = rd_i.word >> 1;
        cnt_d   = CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      out_v_q <= out_v_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

// File: sv/three_digit_segment_shifter_core.sv
// a pushed word passes the digit-pipeline stages, the word queue and the output register before its first pulse appears
// the serializer emits one pulse per cycle while its output is popped, SHIFT_BITS clock pulses and a latch pulse
//   per word; the digit pipeline and word queue take a new word each cycle while the queue is not full
// reset: asynchronous active low, clears pipeline valids, queue and serializer; nothing pending
`default_nettype none
module three_digit_segment_shifter_core #(
  parameter int unsigned SHIFT_BITS = tdss_pkg::SHIFT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire tdss_pkg::in_word_t  in_word_i,
  output logic                     empty,
  input  wire logic                pop,
  output tdss_pkg::out_word_t      out_word_o
);
  import tdss_pkg::*;

  seg_xfer_t wr, rd;
  logic      q_full, q_pop;

  tdss_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_word_i (in_word_i),
    .wr_o      (wr),
    .wr_full_i (q_full)
  );

  tdss_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .full_o (q_full),
    .rd_o   (rd),
    .pop_i  (q_pop)
  );

  tdss_back #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .pop_o      (q_pop),
    .empty_o    (empty),
    .out_word_o (out_word_o),
    .pop_i      (pop)
  );

endmodule
`default_nettype wire
